/* rtl/core/nrl_pkg.sv */
// Shared types, command and status codes for the nearest rectangle locator.
package nrl_pkg;

	localparam int MAX_RECTS_DEF = 16;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_POINT  = 2'd2;
	localparam logic [1:0] CMD_EDGE   = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0]        size_w;
		logic [14:0]        size_h;
		logic [3:0]         entry_select;
	} request_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] found_index;
		logic       is_leftmost;
		logic       is_rightmost;
		logic       is_topmost;
		logic       is_bottommost;
	} response_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} rect_t;

	typedef struct packed {
		logic [1:0] cmd;
		rect_t      rect;
		logic [3:0] sel;
	} op_t;

endpackage

/* rtl/core/nrl_front.sv */
// Front end: takes requests, decodes them into operations, queues them for the back end.
module nrl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  nrl_pkg::request_t request,
	output logic              op_valid,
	output nrl_pkg::op_t      op,
	input  logic              op_take
);
	import nrl_pkg::*;

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);

	op_t           slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	op_t           dec;
	logic          do_push;
	logic          do_pop;

	// decode: point the rectangle fields at the request, size only matters for append
	always_comb begin
		dec.cmd    = request.command;
		dec.rect.x = request.pos_x;
		dec.rect.y = request.pos_y;
		dec.rect.w = (request.command == CMD_APPEND) ? request.size_w : '0;
		dec.rect.h = (request.command == CMD_APPEND) ? request.size_h : '0;
		dec.sel    = (request.command == CMD_EDGE) ? request.entry_select : '0;
	end

	assign full     = (fill_q == FW'(DEPTH));
	assign op_valid = (fill_q != '0);
	assign op       = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = op_take && op_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

/* rtl/core/nrl_back.sv */
// Back end: rectangle table, walk over stored entries and the response queue.
module nrl_back #(
	parameter int MAX_RECTS = nrl_pkg::MAX_RECTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	input  nrl_pkg::op_t       op,
	output logic               op_take,
	output logic               empty,
	input  logic               pop,
	output nrl_pkg::response_t response
);
	import nrl_pkg::*;

	localparam int IW    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CW    = $clog2(MAX_RECTS + 1);
	localparam int ODEPTH = 2;
	localparam int OPW   = $clog2(ODEPTH);
	localparam int OFW   = $clog2(ODEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SEL   = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	function automatic logic [16:0] axis_gap(input logic signed [15:0] p,
		input logic signed [15:0] s, input logic [14:0] n);
		logic signed [17:0] p18;
		logic signed [17:0] s18;
		logic signed [17:0] e18;
		logic signed [17:0] g;
		p18 = $signed({{2{p[15]}}, p});
		s18 = $signed({{2{s[15]}}, s});
		e18 = s18 + $signed({3'b000, n});
		if (p18 < s18) begin
			g = s18 - p18;
		end else if (p18 < e18) begin
			g = '0;
		end else begin
			g = p18 - e18 + 18'sd1;
		end
		return g[16:0];
	endfunction

	// table and control
	rect_t              mem [MAX_RECTS];
	rect_t              rd_q;
	logic [2:0]         state_q;
	op_t                op_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      idx_q;
	logic [1:0]         status_q;
	logic signed [17:0] m_x0_q, m_x1_q, m_y0_q, m_y1_q;

	// walk pipeline
	logic               v_s1, v_s2, v_s3;
	logic [IW-1:0]      idx_s1, idx_s2, idx_s3;
	logic [16:0]        gx_s2, gy_s2;
	logic               inside_s2, inside_s3;
	logic [3:0]         clr_s2;
	logic [32:0]        sqx_s3, sqy_s3;

	// accumulators
	logic               hit_q;
	logic               best_v_q;
	logic [IW-1:0]      best_idx_q;
	logic [33:0]        best_d_q;
	logic [3:0]         flags_q;

	// response queue
	response_t          oslot_q [ODEPTH];
	logic [OPW-1:0]     owr_q, ord_q;
	logic [OFW-1:0]     ofill_q;

	logic               cnt_full, sel_bad, walk_last, pipe_busy, out_full;
	logic               rd_en, mem_we, res_push, res_pop;
	logic [IW-1:0]      rd_addr;
	logic [16:0]        gx_d, gy_d;
	logic signed [17:0] ix0, ix1, iy0, iy1;
	logic               rows, cols, skip;
	logic [3:0]         clr_d;
	logic [33:0]        dsum;
	response_t          res_d;

	assign cnt_full  = (count_q == CW'(MAX_RECTS));
	assign sel_bad   = ({{CW{1'b0}}, op.sel} >= {4'b0000, count_q});
	assign walk_last = ((CW'(idx_q) + CW'(1)) == count_q);
	assign pipe_busy = v_s1 || v_s2 || v_s3;
	assign out_full  = (ofill_q == OFW'(ODEPTH));

	assign op_take  = (state_q == S_IDLE) && op_valid;
	assign mem_we   = op_take && (op.cmd == CMD_APPEND) && !cnt_full;
	assign rd_en    = (op_take && (op.cmd == CMD_EDGE) && !sel_bad) || (state_q == S_WALK);
	assign rd_addr  = (state_q == S_IDLE) ? IW'(op.sel) : idx_q;
	assign res_push = (state_q == S_DONE) && !out_full;
	assign res_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[count_q[IW-1:0]] <= op.rect;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// per-entry work on the read data
	always_comb begin
		gx_d = axis_gap(op_q.rect.x, rd_q.x, rd_q.w);
		gy_d = axis_gap(op_q.rect.y, rd_q.y, rd_q.h);
		ix0  = $signed({{2{rd_q.x[15]}}, rd_q.x});
		iy0  = $signed({{2{rd_q.y[15]}}, rd_q.y});
		ix1  = ix0 + $signed({3'b000, rd_q.w});
		iy1  = iy0 + $signed({3'b000, rd_q.h});
		rows = ((iy0 >= m_y0_q) && (iy0 < m_y1_q)) || ((iy1 > m_y0_q) && (iy1 <= m_y1_q));
		cols = ((ix0 >= m_x0_q) && (ix0 < m_x1_q)) || ((ix1 > m_x0_q) && (ix1 <= m_x1_q));
		skip = (idx_s1 == IW'(op_q.sel));
		clr_d = skip ? 4'b0000 : {rows && (ix0 < m_x0_q), rows && (ix1 > m_x1_q),
			cols && (iy0 < m_y0_q), cols && (iy1 > m_y1_q)};
		dsum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	always_comb begin
		res_d.status        = status_q;
		res_d.found_index   = (op_q.cmd == CMD_POINT) ? 4'(best_idx_q) : 4'd0;
		res_d.is_leftmost   = (op_q.cmd == CMD_EDGE) && flags_q[3];
		res_d.is_rightmost  = (op_q.cmd == CMD_EDGE) && flags_q[2];
		res_d.is_topmost    = (op_q.cmd == CMD_EDGE) && flags_q[1];
		res_d.is_bottommost = (op_q.cmd == CMD_EDGE) && flags_q[0];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (op_take) begin
			op_q <= op;
		end
		if (state_q == S_SEL) begin
			m_x0_q <= $signed({{2{rd_q.x[15]}}, rd_q.x});
			m_y0_q <= $signed({{2{rd_q.y[15]}}, rd_q.y});
			m_x1_q <= $signed({{2{rd_q.x[15]}}, rd_q.x}) + $signed({3'b000, rd_q.w});
			m_y1_q <= $signed({{2{rd_q.y[15]}}, rd_q.y}) + $signed({3'b000, rd_q.h});
		end
		idx_s1    <= idx_q;
		idx_s2    <= idx_s1;
		idx_s3    <= idx_s2;
		gx_s2     <= gx_d;
		gy_s2     <= gy_d;
		inside_s2 <= (gx_d == '0) && (gy_d == '0);
		clr_s2    <= clr_d;
		inside_s3 <= inside_s2;
		sqx_s3    <= 33'(gx_s2) * 33'(gx_s2);
		sqy_s3    <= 33'(gy_s2) * 33'(gy_s2);
		if (v_s3 && (op_q.cmd == CMD_POINT) && !hit_q && !inside_s3 &&
			(!best_v_q || (dsum < best_d_q))) begin
			best_d_q <= dsum;
		end
		if (res_push) begin
			oslot_q[owr_q] <= res_d;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			status_q   <= STATUS_OK;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			hit_q      <= 1'b0;
			best_v_q   <= 1'b0;
			best_idx_q <= '0;
			flags_q    <= 4'b1111;
		end else begin
			v_s1 <= (state_q == S_WALK);
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			if (v_s2 && (op_q.cmd == CMD_EDGE)) begin
				flags_q <= flags_q & ~clr_s2;
			end
			if (v_s3 && (op_q.cmd == CMD_POINT) && !hit_q) begin
				if (inside_s3) begin
					hit_q      <= 1'b1;
					best_idx_q <= idx_s3;
				end else if (!best_v_q || (dsum < best_d_q)) begin
					best_v_q   <= 1'b1;
					best_idx_q <= idx_s3;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						status_q   <= STATUS_OK;
						idx_q      <= '0;
						hit_q      <= 1'b0;
						best_v_q   <= 1'b0;
						best_idx_q <= '0;
						flags_q    <= 4'b1111;
						unique case (op.cmd)
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							CMD_APPEND: begin
								if (cnt_full) begin
									status_q <= STATUS_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_DONE;
							end
							CMD_POINT: begin
								state_q <= (count_q == '0) ? S_DONE : S_WALK;
							end
							default: begin
								if (sel_bad) begin
									status_q <= STATUS_BAD_INDEX;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_SEL;
								end
							end
						endcase
					end
				end
				S_SEL: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					idx_q <= idx_q + IW'(1);
					if (walk_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response queue
	assign empty    = (ofill_q == '0);
	assign response = oslot_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q   <= '0;
			ord_q   <= '0;
			ofill_q <= '0;
		end else begin
			if (res_push) begin
				owr_q <= owr_q + OPW'(1);
			end
			if (res_pop) begin
				ord_q <= ord_q + OPW'(1);
			end
			if (res_push && !res_pop) begin
				ofill_q <= ofill_q + OFW'(1);
			end else if (res_pop && !res_push) begin
				ofill_q <= ofill_q - OFW'(1);
			end
		end
	end

endmodule

/* rtl/core/nearest_rectangle_locator_unit.sv */
// Top level of the nearest rectangle locator: request queue, front end and back end.
//
// Usage notes:
// - Request side looks like a queue: drive request and push; a request is taken on a
//   clock edge with push high and full low. Commands: clear, append rectangle,
//   point query, edge query.
// - Response side looks like a queue: while empty is low the oldest response sits on
//   response; it is taken on an edge with pop high.
// - The front end decodes requests into a two-entry queue; the back end runs one
//   request at a time against a single-port rectangle memory (one read per cycle).
// - Back end steps per request: clear and append go straight to the done state; a point
//   query walks the N stored rectangles, one entry per cycle, drains the walk pipeline
//   and then finishes; an edge query first reads the selected entry, then does the same.
// - An idle back end takes a pushed request in the cycle right after the push edge.
// - Reset empties both queues and the table count; table contents are not cleared,
//   and entries at or beyond the count are never read.
// - When the receiver stalls, up to two responses are held, then the back end waits
//   and the request queue fills and raises full; nothing is dropped.
module nearest_rectangle_locator_unit #(
	parameter int MAX_RECTS = nrl_pkg::MAX_RECTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  nrl_pkg::request_t  request,
	output logic               empty,
	input  logic               pop,
	output nrl_pkg::response_t response
);
	import nrl_pkg::*;

	op_t  op;
	logic op_valid;
	logic op_take;

	// request decode and queue
	nrl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	// table, walker and response queue
	nrl_back #(
		.MAX_RECTS (MAX_RECTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

endmodule

/* rtl/core/nrl_checker.sv */
// Port-level checks for the nearest rectangle locator, bound to its top level.
module nrl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic               empty,
	input logic               pop,
	input nrl_pkg::response_t response
);
	import nrl_pkg::*;

	// reset leaves both queues empty
	a_reset_queues: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not empty under reset");

	// a waiting response only leaves by pop
	a_resp_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("response lost without pop");

	// a waiting response holds its value
	a_resp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(response))
		else $error("waiting response changed");

	// the request queue only fills through a push
	a_full_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose without a push");

endmodule

bind nearest_rectangle_locator_unit nrl_checker u_nrl_checker (.*);

/* test/nearest_rectangle_locator_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the nearest rectangle locator unit: directed table, then random requests.
module nearest_rectangle_locator_unit_test;
	import nrl_pkg::*;

	localparam int TABLE_DEPTH     = MAX_RECTS_DEF;
	localparam int RANDOM_REQUESTS = 750;
	// Allow margin beyond the longest back end occupancy.
	localparam int DRAIN_CYCLES    = 40;

	// Canned responses for the rows whose answer is obvious.
	localparam response_t RESP_OK   = '{STATUS_OK, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam response_t RESP_FULL = '{STATUS_FULL, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam response_t RESP_BAD  = '{STATUS_BAD_INDEX, 4'd0, 1'b1, 1'b1, 1'b1, 1'b1};

	typedef struct {
		request_t  req;
		int        reps;
		bit        typed;
		response_t resp;
	} directed_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	request_t  request;
	logic      empty;
	logic      pop;
	response_t response;

	// Shadow copy of the rectangle table, updated as each request is taken.
	rect_t rect_store [TABLE_DEPTH];
	int    rect_total;

	response_t     awaited_responses [$];
	directed_row_t directed_rows [$];
	int            fail_count;
	int            send_gap_pct;
	int            recv_gap_pct;

	nearest_rectangle_locator_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.empty    (empty),
		.pop      (pop),
		.response (response)
	);

	always #2 clk = ~clk;

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Distance from a point to a span on one axis; zero-sized spans contain nothing.
	function automatic longint axis_gap(longint p, longint start, longint size);
		if (p >= start && p < start + size)
			return 0;
		if (p < start)
			return start - p;
		return p - (start + size - 1);
	endfunction

	// First containing rectangle, else nearest by squared distance, first one wins a tie.
	function automatic int nearest_rect(longint px, longint py);
		longint          dx;
		longint          dy;
		longint unsigned sq_dist;
		longint unsigned best_dist;
		int              best;
		best      = 0;
		best_dist = '1;
		for (int i = 0; i < rect_total; i++) begin
			dx = axis_gap(px, rect_store[i].x, rect_store[i].w);
			dy = axis_gap(py, rect_store[i].y, rect_store[i].h);
			if (dx == 0 && dy == 0)
				return i;
			sq_dist = dx * dx + dy * dy;
			if (sq_dist < best_dist) begin
				best_dist = sq_dist;
				best      = i;
			end
		end
		return best;
	endfunction

	// Flags in order leftmost, rightmost, topmost, bottommost (msb first).
	function automatic logic [3:0] edge_flags(int sel);
		int   mx0, my0, mx1, my1;
		int   ix0, iy0, ix1, iy1;
		logic leftmost, rightmost, topmost, bottommost;
		mx0        = rect_store[sel].x;
		my0        = rect_store[sel].y;
		mx1        = mx0 + int'(rect_store[sel].w);
		my1        = my0 + int'(rect_store[sel].h);
		leftmost   = 1'b1;
		rightmost  = 1'b1;
		topmost    = 1'b1;
		bottommost = 1'b1;
		for (int i = 0; i < rect_total; i++) begin
			if (i != sel) begin
				ix0 = rect_store[i].x;
				iy0 = rect_store[i].y;
				ix1 = ix0 + int'(rect_store[i].w);
				iy1 = iy0 + int'(rect_store[i].h);
				// shares rows with the selected rectangle
				if ((iy0 >= my0 && iy0 < my1) || (iy1 > my0 && iy1 <= my1)) begin
					if (ix0 < mx0) leftmost = 1'b0;
					if (ix1 > mx1) rightmost = 1'b0;
				end
				// shares columns
				if ((ix0 >= mx0 && ix0 < mx1) || (ix1 > mx0 && ix1 <= mx1)) begin
					if (iy0 < my0) topmost = 1'b0;
					if (iy1 > my1) bottommost = 1'b0;
				end
			end
		end
		return {leftmost, rightmost, topmost, bottommost};
	endfunction

	// Applies one request to the shadow table and returns the response it should give.
	function automatic response_t predict_response(request_t r);
		response_t  res;
		logic [3:0] flags;
		res = RESP_OK;
		case (r.command)
			CMD_CLEAR: begin
				rect_total = 0;
			end
			CMD_APPEND: begin
				if (rect_total >= TABLE_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					rect_store[rect_total] = '{r.pos_x, r.pos_y, r.size_w, r.size_h};
					rect_total++;
				end
			end
			CMD_POINT: begin
				res.found_index = 4'(nearest_rect(r.pos_x, r.pos_y));
			end
			default: begin
				if (int'(r.entry_select) >= rect_total) begin
					res = RESP_BAD;
				end else begin
					flags             = edge_flags(r.entry_select);
					res.is_leftmost   = flags[3];
					res.is_rightmost  = flags[2];
					res.is_topmost    = flags[1];
					res.is_bottommost = flags[0];
				end
			end
		endcase
		return res;
	endfunction

	function automatic void add_row(logic [1:0] cmd, int x, int y, int w, int h, int sel,
			int reps, bit typed, response_t resp);
		directed_row_t row;
		row.req   = '{cmd, 16'(x), 16'(y), 15'(w), 15'(h), 4'(sel)};
		row.reps  = reps;
		row.typed = typed;
		row.resp  = resp;
		directed_rows.push_back(row);
	endfunction

	// Mostly a cluster near the origin so that containment and neighbours happen;
	// now and then full-range values so every bit moves.
	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		bit          wide;
		pick = $urandom_range(99);
		wide = ($urandom_range(9) < 2);
		r.command = (pick < 4) ? CMD_CLEAR : (pick < 40) ? CMD_APPEND :
			(pick < 72) ? CMD_POINT : CMD_EDGE;
		if (wide) begin
			r.pos_x  = 16'($urandom);
			r.pos_y  = 16'($urandom);
			r.size_w = 15'($urandom);
			r.size_h = 15'($urandom);
		end else begin
			r.pos_x  = 16'(int'($urandom_range(400)) - 200);
			r.pos_y  = 16'(int'($urandom_range(400)) - 200);
			r.size_w = ($urandom_range(9) == 0) ? 15'd0 : 15'($urandom_range(120));
			r.size_h = ($urandom_range(9) == 0) ? 15'd0 : 15'($urandom_range(120));
		end
		// edge queries mostly pick a live entry, sometimes any index
		if (rect_total > 0 && $urandom_range(99) < 85)
			r.entry_select = 4'($urandom_range(rect_total - 1));
		else
			r.entry_select = 4'($urandom);
		return r;
	endfunction

	// Offers one request, waits for it to be taken, then records what should come back.
	// full is looked at on the falling edge, where it is settled.
	task automatic send_request(request_t req_in, bit typed, response_t typed_resp);
		response_t predicted;
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		request <= req_in;
		@(negedge clk);
		while (full)
			@(negedge clk);
		@(posedge clk);
		predicted = predict_response(req_in);
		awaited_responses.push_back(typed ? typed_resp : predicted);
	endtask

	task automatic compare_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_response(response_t got);
		response_t want;
		if (awaited_responses.size() == 0) begin
			$error("response %h with no request outstanding", got);
			fail_count++;
		end else begin
			want = awaited_responses.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("found_index", want.found_index, got.found_index);
			compare_field("is_leftmost", want.is_leftmost, got.is_leftmost);
			compare_field("is_rightmost", want.is_rightmost, got.is_rightmost);
			compare_field("is_topmost", want.is_topmost, got.is_topmost);
			compare_field("is_bottommost", want.is_bottommost, got.is_bottommost);
		end
	endtask

	// Receiver: pop chosen afresh every cycle.
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_gap_pct);
	end

	// pop and empty are steady at the falling edge; a pop seen here lands on the next rise.
	always @(negedge clk) begin
		if (arst_n && pop && !empty)
			check_response(response);
	end

	initial begin
		push         = 1'b0;
		pop          = 1'b0;
		request      = '0;
		arst_n       = 1'b0;
		rect_total   = 0;
		fail_count   = 0;
		send_gap_pct = 26;
		recv_gap_pct = 55;

		// Empty table: point query gives index 0, edge query a bad index.
		add_row(CMD_POINT, 0, 0, 0, 0, 0, 1, 1'b1, RESP_OK);
		add_row(CMD_EDGE, 0, 0, 0, 0, 0, 1, 1'b1, RESP_BAD);
		add_row(CMD_EDGE, -1, -1, 32767, 32767, 15, 1, 1'b1, RESP_BAD);
		// Extreme corners, a zero-sized and a zero-width rectangle.
		add_row(CMD_APPEND, -32768, -32768, 32767, 32767, 0, 1, 1'b1, RESP_OK);
		add_row(CMD_APPEND, 32767, 32767, 0, 0, 15, 1, 1'b1, RESP_OK);
		add_row(CMD_APPEND, 100, -200, 0, 50, 0, 1, 1'b1, RESP_OK);
		add_row(CMD_POINT, 32767, 32767, 0, 0, 0, 1, 1'b0, RESP_OK);
		add_row(CMD_POINT, -32768, -32768, 0, 0, 0, 1, 1'b0, RESP_OK);
		add_row(CMD_POINT, 100, -150, 0, 0, 0, 1, 1'b0, RESP_OK);
		add_row(CMD_POINT, 32767, -32768, 0, 0, 0, 1, 1'b0, RESP_OK);
		add_row(CMD_EDGE, 0, 0, 0, 0, 0, 1, 1'b0, RESP_OK);
		add_row(CMD_EDGE, 0, 0, 0, 0, 1, 1, 1'b0, RESP_OK);
		add_row(CMD_EDGE, 0, 0, 0, 0, 2, 1, 1'b0, RESP_OK);
		add_row(CMD_EDGE, 0, 0, 0, 0, 3, 1, 1'b1, RESP_BAD);
		add_row(CMD_CLEAR, 0, 0, 0, 0, 0, 1, 1'b1, RESP_OK);
		add_row(CMD_POINT, 5, 5, 0, 0, 0, 1, 1'b1, RESP_OK);
		// Fill with identical rectangles: ties must keep the first; then overflow.
		add_row(CMD_APPEND, 0, 0, 10, 10, 0, TABLE_DEPTH, 1'b1, RESP_OK);
		add_row(CMD_APPEND, 1, 1, 1, 1, 0, 1, 1'b1, RESP_FULL);
		add_row(CMD_POINT, 20, 20, 0, 0, 0, 1, 1'b0, RESP_OK);
		add_row(CMD_EDGE, 0, 0, 0, 0, 15, 1, 1'b0, RESP_OK);
		add_row(CMD_EDGE, 0, 0, 0, 0, 0, 1, 1'b0, RESP_OK);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			repeat (directed_rows[i].reps)
				send_request(directed_rows[i].req, directed_rows[i].typed,
					directed_rows[i].resp);
		end

		// Three pressure phases: slow receiver, slow sender, then flat out.
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 26 : (phase == 1) ? 55 : 0;
			recv_gap_pct = (phase == 0) ? 55 : (phase == 1) ? 26 : 0;
			repeat (RANDOM_REQUESTS / 3)
				send_request(random_request(), 1'b0, RESP_OK);
		end
		push <= 1'b0;

		while (awaited_responses.size() != 0)
			@(posedge clk);
		// catch any stray extra response
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
